// ===== rtl/core/mexp_pkg.sv =====
// mexp_pkg: shared constants for the modular exponentiation block
// register map, reset values and default widths; no dependencies

package mexp_pkg;

    // default operand width
    localparam int VALUE_BITS_DEFAULT = 16;

    // configuration port shape
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_EXPONENT = 1'b0;
    localparam logic [0:0] REG_MODULUS  = 1'b1;

    // register reset values, truncated to the operand width where used
    localparam logic [31:0] EXPONENT_RESET = 32'd1;
    localparam logic [31:0] MODULUS_RESET  = 32'd65535;

endpackage

// ===== rtl/core/mexp_mulmod.sv =====
// mexp_mulmod: iterative modular multiplier, result = a * b mod m
// takes a one bit at a time, each bit a double and reduce then an add and reduce step; uses mexp_pkg

module mexp_mulmod #(
    parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    input  logic [VALUE_BITS-1:0] m,
    output logic                  done,
    output logic [VALUE_BITS-1:0] result
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    // b must be below m; the partial remainder stays below m throughout
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic [VALUE_BITS-1:0] b_reg, b_next;
    logic [VALUE_BITS-1:0] m_reg, m_next;
    logic [VALUE_BITS-1:0] r_reg, r_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  phase_reg, phase_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [VALUE_BITS:0] m_ext;
    logic [VALUE_BITS:0] step_val;
    logic [VALUE_BITS:0] step_red;

    assign m_ext = {1'b0, m_reg};

    // shared compare and subtract
    always_comb
    begin
        if (!phase_reg)
        begin
            step_val = {r_reg, 1'b0};
        end
        else if (a_reg[VALUE_BITS-1])
        begin
            step_val = {1'b0, r_reg} + {1'b0, b_reg};
        end
        else
        begin
            step_val = {1'b0, r_reg};
        end
        step_red = (step_val >= m_ext) ? (step_val - m_ext) : step_val;
    end

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            a_next     = a;
            b_next     = b;
            m_next     = m;
            r_next     = '0;
            cnt_next   = CNT_BITS'(VALUE_BITS);
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next     = step_red[VALUE_BITS-1:0];
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                a_next   = {a_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ===== rtl/core/modular_exponentiation_unit.sv =====
// modular_exponentiation_unit: top level, value^exponent mod modulus
// apb registers, square-and-multiply sequencer; uses mexp_pkg and mexp_mulmod

// Each input beat carries one cipher_value; one output beat returns
// cipher_value^exponent mod modulus, computed right to left by square and
// multiply. The user is to write exponent (address 0) and modulus (address 4)
// over the apb port while the block is idle; the block does not enforce this.
// Writes only take effect for the next beat. A modulus below 2 gives 0. All
// work runs on one shared modular multiplier that takes its first operand one
// bit at a time, each bit a double-and-reduce then an add-and-reduce step. An
// item costs one base reduction plus, for each exponent bit up to the highest
// set bit, a square and, for set bits, a multiply. in_ready is high only
// between items; a finished result waits in the output register, and the next
// item can be accepted while it is not yet taken.

module modular_exponentiation_unit #(
    parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mexp_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mexp_pkg::DATA_BITS-1:0] pwdata,
    output logic [mexp_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [VALUE_BITS-1:0]          cipher_value,
    // output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [VALUE_BITS-1:0]          plain_value
);

    localparam int DATA_W = mexp_pkg::DATA_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SQR    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // configuration registers
    logic [VALUE_BITS-1:0] exponent_reg;
    logic [VALUE_BITS-1:0] modulus_reg;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= VALUE_BITS'(mexp_pkg::EXPONENT_RESET);
            modulus_reg  <= VALUE_BITS'(mexp_pkg::MODULUS_RESET);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                mexp_pkg::REG_EXPONENT: exponent_reg <= VALUE_BITS'(pwdata);
                mexp_pkg::REG_MODULUS:  modulus_reg  <= VALUE_BITS'(pwdata);
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[2])
            mexp_pkg::REG_EXPONENT: prdata = DATA_W'(exponent_reg);
            mexp_pkg::REG_MODULUS:  prdata = DATA_W'(modulus_reg);
            default:                prdata = '0;
        endcase
    end

    // sequencer and working registers
    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] exp_reg, exp_next;        // remaining exponent
    logic [VALUE_BITS-1:0] mod_reg, mod_next;        // modulus latched per item
    logic [VALUE_BITS-1:0] acc_reg, acc_next;        // running result
    logic [VALUE_BITS-1:0] base_reg, base_next;      // running base
    logic                  mm_start_reg, mm_start_next;
    logic [VALUE_BITS-1:0] mm_a_reg, mm_a_next;
    logic [VALUE_BITS-1:0] mm_b_reg, mm_b_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] plain_reg, plain_next;

    logic                  mm_done;
    logic [VALUE_BITS-1:0] mm_result;
    logic [VALUE_BITS-1:0] exp_shift;
    logic                  in_beat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign exp_shift = exp_reg >> 1;

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        mm_start_next  = 1'b0;
        mm_a_next      = mm_a_reg;
        mm_b_next      = mm_b_reg;
        out_valid_next = out_valid_reg;
        plain_next     = plain_reg;

        // output register drains independently of the sequencer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    exp_next = exponent_reg;
                    mod_next = modulus_reg;
                    if (modulus_reg < VALUE_BITS'(2))
                    begin
                        // degenerate modulus: everything reduces to zero
                        acc_next   = '0;
                        base_next  = '0;
                        exp_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // base reduction: cipher * 1 mod m
                        mm_a_next     = cipher_value;
                        mm_b_next     = VALUE_BITS'(1);
                        mm_start_next = 1'b1;
                        state_next    = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    base_next = mm_result;
                    acc_next  = VALUE_BITS'(1);
                    if (exp_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (exp_reg[0])
                    begin
                        mm_a_next     = VALUE_BITS'(1);
                        mm_b_next     = mm_result;
                        mm_start_next = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        mm_a_next     = mm_result;
                        mm_b_next     = mm_result;
                        mm_start_next = 1'b1;
                        state_next    = S_SQR;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    acc_next      = mm_result;
                    mm_a_next     = base_reg;
                    mm_b_next     = base_reg;
                    mm_start_next = 1'b1;
                    state_next    = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mm_done)
                begin
                    base_next = mm_result;
                    exp_next  = exp_shift;
                    if (exp_shift == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (exp_shift[0])
                    begin
                        mm_a_next     = acc_reg;
                        mm_b_next     = mm_result;
                        mm_start_next = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        mm_a_next     = mm_result;
                        mm_b_next     = mm_result;
                        mm_start_next = 1'b1;
                        state_next    = S_SQR;
                    end
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    plain_next     = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mm_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= VALUE_BITS'(1);
            base_reg      <= '0;
            exp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mm_start_reg  <= mm_start_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            base_reg      <= base_next;
            exp_reg       <= exp_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mod_reg   <= mod_next;
        mm_a_reg  <= mm_a_next;
        mm_b_reg  <= mm_b_next;
        plain_reg <= plain_next;
    end

    // shared modular multiplier
    mexp_mulmod #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start_reg),
        .a      (mm_a_reg),
        .b      (mm_b_reg),
        .m      (mod_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    assign out_valid   = out_valid_reg;
    assign plain_value = plain_reg;

endmodule

// ===== tb/modular_exponentiation_unit_tb.sv =====
// modular_exponentiation_unit_tb: self-checking bench for modular_exponentiation_unit
// predicts cipher^exponent mod modulus per beat, random idling on both channels
// depends on mexp_pkg and the rtl of modular_exponentiation_unit
`timescale 1ns / 100ps

module modular_exponentiation_unit_tb;

    localparam int VB        = mexp_pkg::VALUE_BITS_DEFAULT;
    localparam int ADDR_BITS = mexp_pkg::ADDR_BITS;
    localparam int DATA_BITS = mexp_pkg::DATA_BITS;

    // watchdog: slowest legal item plus worst stall and gap on each side,
    // times the 452 beats, then several times over
    localparam int unsigned LIMIT = 6000000;
    // receiver hold-off long enough to back the block up into its input
    localparam int unsigned HOLD_CYCLES = 4000;
    // settle time after the last result, about one worst-case item
    localparam int unsigned LINGER = 1200;
    localparam int RANDOM_BEATS = 430;

    localparam logic [ADDR_BITS-1:0] ADDR_EXPONENT = {mexp_pkg::REG_EXPONENT, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_MODULUS  = {mexp_pkg::REG_MODULUS, 2'b00};

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_BITS-1:0] paddr        = '0;
    logic [DATA_BITS-1:0] pwdata       = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [VB-1:0]        cipher_value = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [VB-1:0]        plain_value;

    modular_exponentiation_unit #(
        .VALUE_BITS (VB)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cipher_value (cipher_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .plain_value  (plain_value)
    );

    // key currently loaded in the block, as the predictor sees it
    logic [VB-1:0] key_exponent;
    logic [VB-1:0] key_modulus;

    logic [VB-1:0] cipher_backlog[$];   // cipher values not yet offered
    logic [VB-1:0] plain_expected[$];   // predicted plaintexts, oldest first

    int unsigned error_count   = 0;
    int unsigned cipher_beats  = 0;
    int unsigned plain_beats   = 0;
    int unsigned key_settings  = 0;
    int unsigned cycle_count   = 0;

    // phase controls, set by the sequence, read by the channel processes
    bit steady       = 1'b0;   // no idling on either side
    bit squeeze_arm  = 1'b0;   // ask the receiver for one long hold-off
    bit squeeze_done = 1'b0;

    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned recv_draw;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, plain_expected.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned draw_gap();
        int unsigned r;
        int unsigned g;
        r = $urandom_range(0, 99);
        if (r < 50)
            g = 0;
        else if (r < 85)
            g = $urandom_range(1, 4);
        else if (r < 97)
            g = $urandom_range(5, 60);
        else
            g = $urandom_range(200, 1500);
        return g;
    endfunction

    // right-to-left square and multiply at full double width
    function automatic logic [VB-1:0] power_mod(logic [VB-1:0] base_in);
        logic [2*VB-1:0] acc;
        logic [2*VB-1:0] sq;
        logic [VB-1:0]   bits_left;
        acc = '0;
        if (key_modulus != '0)
        begin
            acc       = 1 % key_modulus;
            sq        = base_in % key_modulus;
            bits_left = key_exponent;
            while (bits_left != '0)
            begin
                if (bits_left[0])
                    acc = (acc * sq) % key_modulus;
                bits_left = bits_left >> 1;
                sq = (sq * sq) % key_modulus;
            end
        end
        // modulus zero answers zero
        return acc[VB-1:0];
    endfunction

    // append one cipher value to the backlog
    task automatic queue_cipher(input logic [VB-1:0] v);
        cipher_backlog.insert(cipher_backlog.size(), v);
    endtask

    // sender: one cipher beat at a time from the backlog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            cipher_value <= '0;
            send_gap     <= 0;
        end
        else
        begin
            // accepted beat: predict its plaintext with the key now loaded
            if (in_valid && in_ready)
            begin
                plain_expected.insert(plain_expected.size(), power_mod(cipher_value));
                cipher_beats = cipher_beats + 1;
            end
            // slot free: idle out the gap or present the next beat
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cipher_backlog.size() != 0)
                begin
                    cipher_value <= cipher_backlog.pop_front();
                    in_valid     <= 1'b1;
                    send_gap     <= (steady || squeeze_arm) ? 0 : draw_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each plaintext beat, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            recv_stall   <= 0;
            squeeze_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                plain_beats = plain_beats + 1;
                if (plain_expected.size() == 0)
                begin
                    $error("plain_value beat with nothing expected: got %0d", plain_value);
                    error_count = error_count + 1;
                end
                else if (plain_value !== plain_expected[0])
                begin
                    $error("plain_value mismatch: expected %0d, got %0d",
                           plain_expected[0], plain_value);
                    error_count = error_count + 1;
                    void'(plain_expected.pop_front());
                end
                else
                begin
                    void'(plain_expected.pop_front());
                end
            end

            if (squeeze_arm && !squeeze_done)
            begin
                // long hold-off, counted here while the sender keeps offering
                squeeze_done <= 1'b1;
                recv_stall   <= HOLD_CYCLES;
                out_ready    <= 1'b0;
            end
            else if (recv_stall != 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
            end
            else if ((out_valid && out_ready) || $urandom_range(0, 63) == 0)
            begin
                // stalls land after a beat or anywhere in the block's work
                recv_draw = draw_gap();
                if (recv_draw != 0)
                begin
                    recv_stall <= recv_draw - 1;
                    out_ready  <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_transfer(input logic wr, input logic [ADDR_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] wdata,
                                output logic [DATA_BITS-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register read with a check against the predictor's copy
    task automatic check_register(input logic [ADDR_BITS-1:0] addr,
                                  input logic [VB-1:0] want, input string field);
        logic [DATA_BITS-1:0] rd;
        apb_transfer(1'b0, addr, '0, rd);
        if (rd[VB-1:0] !== want)
        begin
            $error("%s readback mismatch: expected %0d, got %0d", field, want, rd[VB-1:0]);
            error_count = error_count + 1;
        end
    endtask

    // wait until nothing is queued, offered or owed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cipher_backlog.size() != 0 || in_valid || plain_expected.size() != 0);
    endtask

    // load a new key while idle; upper data bits are junk half the time
    task automatic load_key(input logic [VB-1:0] exp_word, input logic [VB-1:0] mod_word);
        logic [DATA_BITS-1:0] wd;
        logic [DATA_BITS-1:0] rd;
        wait_drained();
        wd = $urandom();
        if ($urandom_range(0, 1) == 0)
            wd = '0;
        wd[VB-1:0] = exp_word;
        apb_transfer(1'b1, ADDR_EXPONENT, wd, rd);
        key_exponent = exp_word;
        wd = $urandom();
        if ($urandom_range(0, 1) == 0)
            wd = '0;
        wd[VB-1:0] = mod_word;
        apb_transfer(1'b1, ADDR_MODULUS, wd, rd);
        key_modulus = mod_word;
        check_register(ADDR_EXPONENT, key_exponent, "exponent");
        check_register(ADDR_MODULUS, key_modulus, "modulus");
        key_settings = key_settings + 1;
        @(negedge clk);
    endtask

    // exponent: a few extremes, otherwise a random bit length
    function automatic logic [VB-1:0] pick_exponent();
        int unsigned r;
        int unsigned len;
        logic [31:0] e;
        r = $urandom_range(0, 99);
        if (r < 8)
            e = 0;
        else if (r < 16)
            e = 32'hFFFF;
        else if (r < 22)
            e = 1;
        else
        begin
            len = $urandom_range(1, VB);
            e   = ($urandom() & ((32'd1 << len) - 1)) | (32'd1 << (len - 1));
        end
        return e[VB-1:0];
    endfunction

    // modulus: mostly in range, rarely the degenerate zero and one
    function automatic logic [VB-1:0] pick_modulus();
        int unsigned r;
        logic [31:0] m;
        r = $urandom_range(0, 99);
        if (r < 5)
            m = $urandom_range(0, 1);
        else if (r < 15)
            m = 2;
        else if (r < 25)
            m = 32'hFFFF;
        else if (r < 40)
            m = $urandom_range(3, 255);
        else
            m = $urandom_range(2, 65535);
        return m[VB-1:0];
    endfunction

    // cipher value: full range, extremes, and values around the modulus
    function automatic logic [VB-1:0] pick_cipher();
        int unsigned r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
            v = 0;
        else if (r < 16)
            v = 65535;
        else if (r < 26)
        begin
            v = int'(key_modulus) + int'($urandom_range(0, 2)) - 1;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
        end
        else
            v = $urandom_range(0, 65535);
        return v[VB-1:0];
    endfunction

    // test sequence
    initial
    begin : sequencer
        int left;
        int n;
        int phase_idx;

        key_exponent = VB'(mexp_pkg::EXPONENT_RESET);
        key_modulus  = VB'(mexp_pkg::MODULUS_RESET);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset key: identity power, modulus 65535
        check_register(ADDR_EXPONENT, key_exponent, "exponent");
        check_register(ADDR_MODULUS, key_modulus, "modulus");
        @(negedge clk);
        queue_cipher(16'd0);
        queue_cipher(16'd1);
        queue_cipher(16'd65534);
        queue_cipher(16'd65535);     // reduces to zero first
        queue_cipher(16'hAAAA);
        queue_cipher(16'h5555);

        // exponent zero gives one
        load_key(16'd0, 16'd65535);
        queue_cipher(16'd0);
        queue_cipher(16'd65535);
        queue_cipher(16'd12345);

        // longest exponent, largest modulus
        load_key(16'hFFFF, 16'd65535);
        queue_cipher(16'd2);
        queue_cipher(16'd65534);

        // smallest legal modulus
        load_key(16'hFFFF, 16'd2);
        queue_cipher(16'd0);
        queue_cipher(16'd1);
        queue_cipher(16'd65535);

        // prime modulus, exponent p-2 gives the inverse
        load_key(16'd65519, 16'd65521);
        queue_cipher(16'd3);
        queue_cipher(16'd65535);

        // small textbook key pair
        load_key(16'd2753, 16'd3233);
        queue_cipher(16'd2790);
        queue_cipher(16'd3232);

        // modulus one: everything reduces to zero
        load_key(16'd5, 16'd1);
        queue_cipher(16'd7);
        queue_cipher(16'd65535);

        // modulus zero: no reduction defined, answer is zero
        load_key(16'd5, 16'd0);
        queue_cipher(16'd7);
        queue_cipher(16'd65535);

        // random phases, each under a fresh key
        left      = RANDOM_BEATS;
        phase_idx = 0;
        while (left > 0)
        begin
            n = $urandom_range(20, 60);
            if (n > left)
                n = left;
            load_key(pick_exponent(), pick_modulus());
            // first phase backs the block up, second runs without idling
            squeeze_arm = (phase_idx == 0);
            steady      = (phase_idx == 1);
            repeat (n)
                queue_cipher(pick_cipher());
            wait_drained();
            squeeze_arm = 1'b0;
            steady      = 1'b0;
            left        = left - n;
            phase_idx   = phase_idx + 1;
        end

        // settle: catch any late or spurious beat
        repeat (LINGER) @(posedge clk);
        if (plain_expected.size() != 0)
        begin
            $error("plain_value: %0d expected beats never arrived", plain_expected.size());
            error_count = error_count + 1;
        end

        $display("covered %0d cipher beats and %0d plaintext beats under %0d keys",
                 cipher_beats, plain_beats, key_settings);
        $display("including exponent 0 and 65535, modulus 0 to 65535, a long output hold-off");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
